[rtl/core/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, operation codes and pipeline types of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int NUM_W     = 32 + FRAC_BITS;
   localparam int NUM_CELLS = NUM_W;

   localparam logic [31:0] RAW_MAX = 32'h7fff_ffff;
   localparam logic [31:0] RAW_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
      OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
   } op_type;

   // One transaction as it travels down the divider chain
   typedef struct packed {
      logic             valid;
      op_type           op;
      logic             neg;
      logic             dzero;
      logic             err;
      logic             flag;
      logic [31:0]      res;
      logic [31:0]      maga;
      logic [31:0]      den;
      logic [63:0]      prod;
      logic [NUM_W-1:0] num;
      logic [31:0]      rem;
      logic [NUM_W-1:0] quot;
   } stage_type;

   // Clamp a 33-bit signed value to 32 bits; returns {error, value}
   function automatic logic [32:0] sat33(input logic [32:0] v);
      logic [32:0] r;
      begin
         if (v[32] != v[31]) begin
            r = {1'b1, (v[32] ? RAW_MIN : RAW_MAX)};
         end else begin
            r = {1'b0, v[31:0]};
         end
         return r;
      end
   endfunction

endpackage

[rtl/core/fixed_point_alu_unit.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU on 32-bit raw values with a pipelined divider.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_operation, req_operand_a and req_operand_b and raise start; the
//   transaction is taken at that clock edge when busy is low. busy is never
//   raised, so one transaction may be issued every cycle.
//   Every transaction yields one result: rsp_valid strobes for one cycle with
//   rsp_result, rsp_flag and rsp_error. Results leave in issue order.
// Pipeline:
//   every operation passes through the same stages in order: input register,
//   operand stage, multiplier stage, one division cell per quotient bit
//   (32 + FRAC_BITS cells), rounding stage.
// Throughput:
//   one transaction per cycle; each division cell resolves one quotient bit
//   of a different transaction every cycle.
// Reset:
//   synchronous reset drops all transactions in flight; rsp_valid stays low
//   until new transactions reach the end of the pipeline.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit
   import fpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_operation,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result,
   output logic        rsp_flag,
   output logic        rsp_error
);

   stage_type chain [0:NUM_CELLS];
   logic      take;

   assign busy = 1'b0;
   assign take = start && !busy;

   // Register inputs and evaluate the simple operations
   fpa_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .operation (req_operation),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .stage_out (chain[0])
   );

   // Advance each transaction through the division cells
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // Round and deliver
   fpa_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (chain[NUM_CELLS]),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .rsp_flag   (rsp_flag),
      .rsp_error  (rsp_error)
   );

   // Last cell's transaction appears on the result strobe next cycle
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_CELLS].valid |=> rsp_valid)
      else $error("transaction lost at output stage");

   // A true comparison never carries an error or a nonzero result
   a_flag_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag |-> !rsp_error && rsp_result == 32'd0)
      else $error("comparison result carries payload");

   // Division by zero always saturates with error
   a_dzero: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_CELLS].valid && chain[NUM_CELLS].op == OP_DIV &&
      chain[NUM_CELLS].dzero |=> rsp_error &&
      (rsp_result == RAW_MAX || rsp_result == RAW_MIN))
      else $error("division by zero not saturated");

endmodule

[rtl/core/fpa_prep.sv]
// ----------------------------------------------------------------------------
// fpa_prep
// Input register, simple operations, operand magnitudes and the product.
// ----------------------------------------------------------------------------
module fpa_prep
   import fpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [3:0]  operation,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output stage_type   stage_out
);

   logic        valid_ff;
   op_type      op_ff;
   logic [31:0] a_ff;
   logic [31:0] b_ff;
   stage_type   st2_in, st2_ff, st3_in, st3_ff;

   logic [32:0] sum, dif, incv, decv;
   logic [63:0] wide;
   logic        lt, eq;

   // Capture the transaction
   always_ff @(posedge clock) begin
      a_ff  <= operand_a;
      b_ff  <= operand_b;
      op_ff <= op_type'(operation);
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take;
      end
   end

   // Evaluate the simple operations and magnitudes
   always_comb begin
      sum  = {a_ff[31], a_ff} + {b_ff[31], b_ff};
      dif  = {a_ff[31], a_ff} - {b_ff[31], b_ff};
      incv = {a_ff[31], a_ff} + 33'd1;
      decv = {a_ff[31], a_ff} - 33'd1;
      wide = {{32{a_ff[31]}}, a_ff} << FRAC_BITS;
      lt   = $signed(a_ff) < $signed(b_ff);
      eq   = a_ff == b_ff;

      st2_in       = '0;
      st2_in.valid = valid_ff;
      st2_in.op    = op_ff;
      st2_in.neg   = a_ff[31] ^ b_ff[31];
      st2_in.dzero = b_ff == 32'd0;
      st2_in.maga  = a_ff[31] ? (~a_ff + 32'd1) : a_ff;
      st2_in.den   = b_ff[31] ? (~b_ff + 32'd1) : b_ff;
      st2_in.num   = {st2_in.maga, {FRAC_BITS{1'b0}}};

      case (op_ff)
         OP_ADD:   {st2_in.err, st2_in.res} = sat33(sum);
         OP_SUB:   {st2_in.err, st2_in.res} = sat33(dif);
         OP_INC:   {st2_in.err, st2_in.res} = sat33(incv);
         OP_DEC:   {st2_in.err, st2_in.res} = sat33(decv);
         OP_GT:    st2_in.flag = !lt && !eq;
         OP_LT:    st2_in.flag = lt;
         OP_GE:    st2_in.flag = !lt;
         OP_LE:    st2_in.flag = lt || eq;
         OP_EQ:    st2_in.flag = eq;
         OP_NE:    st2_in.flag = !eq;
         OP_MIN:   st2_in.res = lt ? a_ff : b_ff;
         OP_MAX:   st2_in.res = (!lt && !eq) ? a_ff : b_ff;
         OP_TO_INT: st2_in.res = 32'($signed(a_ff) >>> FRAC_BITS);
         OP_FROM_INT: begin
            if (wide[63:31] != {33{wide[31]}}) begin
               st2_in.err = 1'b1;
               st2_in.res = a_ff[31] ? RAW_MIN : RAW_MAX;
            end else begin
               st2_in.res = wide[31:0];
            end
         end
         default: st2_in.res = '0;
      endcase
   end

   // Form the magnitude product
   always_comb begin
      st3_in      = st2_ff;
      st3_in.prod = 64'(st2_ff.maga) * 64'(st2_ff.den);
   end

   // Advance the operand and product stages
   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff <= '0;
         st3_ff <= '0;
      end else begin
         st2_ff <= st2_in;
         st3_ff <= st3_in;
      end
   end

   assign stage_out = st3_ff;

endmodule

[rtl/core/fpa_div_cell.sv]
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division cell: resolves one quotient bit per transaction.
// ----------------------------------------------------------------------------
module fpa_div_cell
   import fpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in,
   output stage_type stage_out
);

   stage_type   cell_in, cell_ff;
   logic [32:0] rem_sh;
   logic [33:0] trial;
   logic        qbit;

   // Shift in the next numerator bit and try a subtract
   always_comb begin
      rem_sh       = {stage_in.rem, stage_in.num[NUM_W-1]};
      trial        = {1'b0, rem_sh} - {2'b00, stage_in.den};
      qbit         = !trial[33];
      cell_in      = stage_in;
      cell_in.rem  = qbit ? trial[31:0] : rem_sh[31:0];
      cell_in.num  = {stage_in.num[NUM_W-2:0], 1'b0};
      cell_in.quot = {stage_in.quot[NUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign stage_out = cell_ff;

endmodule

[rtl/core/fpa_finish.sv]
// ----------------------------------------------------------------------------
// fpa_finish
// Rounding, saturation and sign of products and quotients; output register.
// ----------------------------------------------------------------------------
module fpa_finish
   import fpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  stage_type   stage_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_result,
   output logic        rsp_flag,
   output logic        rsp_error
);

   logic        valid_ff;
   logic [31:0] result_ff, result_in;
   logic        flag_ff, flag_in, error_ff, error_in;
   logic [63:0] mul_mag, div_mag, mag;
   logic        round_up, over;

   // Round, clamp and sign the wide results
   always_comb begin
      mul_mag  = (stage_in.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      round_up = {stage_in.rem, 1'b0} >= {1'b0, stage_in.den};
      div_mag  = 64'(stage_in.quot) + 64'(round_up);
      mag      = (stage_in.op == OP_MUL) ? mul_mag : div_mag;
      over     = stage_in.neg ? (mag > 64'h8000_0000) : (mag > 64'h7fff_ffff);

      result_in = stage_in.res;
      flag_in   = stage_in.flag;
      error_in  = stage_in.err;
      if (stage_in.op == OP_DIV && stage_in.dzero) begin
         error_in  = 1'b1;
         result_in = stage_in.neg ? RAW_MIN : RAW_MAX;
      end else if (stage_in.op == OP_MUL || stage_in.op == OP_DIV) begin
         error_in = over;
         if (over) begin
            result_in = stage_in.neg ? RAW_MIN : RAW_MAX;
         end else begin
            result_in = stage_in.neg ? (~mag[31:0] + 32'd1) : mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      flag_ff   <= flag_in;
      error_ff  <= error_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
   assign rsp_flag   = flag_ff;
   assign rsp_error  = error_ff;

endmodule
